@@ hw/rtl/rotor_cipher_engine_defines.svh @@
// assertion macros for the rotor cipher engine
// expects clk and rst in the scope of the module that uses them
`ifndef ROTOR_CIPHER_ENGINE_DEFINES_SVH
`define ROTOR_CIPHER_ENGINE_DEFINES_SVH

// same-cycle implication, off during reset
`define RCE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rotor cipher engine check failed");

// next-cycle implication, off during reset
`define RCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rotor cipher engine check failed");

`endif

@@ hw/rtl/rce_pkg.sv @@
// shared types, constants and helpers for the rotor cipher engine
// no dependencies
`default_nettype none

package rce_pkg;

  localparam int NUM_ROTORS_DEF = 3;
  localparam int LETTERS        = 26;

  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LZ    = 8'h7A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [1:0] {
    CMD_ENCIPHER  = 2'd0,
    CMD_WRITE     = 2'd1,
    CMD_SET_POS   = 2'd2,
    CMD_SET_NOTCH = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_BAD_CHAR = 2'd1,
    STS_BAD_UNIT = 2'd2
  } status_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOOK,
    ST_WRINV,
    ST_FINAL
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic look;
    logic wr_inv;
    logic final_step;
    logic out_load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_lookup;
    logic needs_inv;
    logic out_free;
  } ctl_sts_t;

  // (c - sub + add) mod 26 for operands in 0..25
  function automatic logic [4:0] shift26(input logic [4:0] c, input logic [4:0] sub,
                                         input logic [4:0] add);
    logic [6:0] t;
    t = 7'(c) + 7'(LETTERS) - 7'(sub) + 7'(add);
    if (t >= 7'(2 * LETTERS)) begin
      t = t - 7'(2 * LETTERS);
    end else if (t >= 7'(LETTERS)) begin
      t = t - 7'(LETTERS);
    end
    return t[4:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rotor_cipher_engine.sv @@
// encipher a letter: the item is latched, then the lookup chain runs at one wiring
// memory read per cycle and the plugboard result is registered; the next item is
// taken once the engine is idle again; space, bad character, position, notch,
// reflector and plugboard writes take the short path, a rotor wiring write also
// writes the inverse entry (forward and inverse entries share one port)
// reset: control idle, plugboard identity, positions and notches zero, wiring not cleared
`default_nettype none

`include "rotor_cipher_engine_defines.svh"

module rotor_cipher_engine #(
  parameter int NUM_ROTORS = rce_pkg::NUM_ROTORS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // char_in, unit_sel, entry_index, entry_value
  input  wire logic [1:0]  s_tuser,   // cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // char_out
  output logic [1:0]       m_tuser    // status
);
  import rce_pkg::*;

  localparam int KW = $clog2(2 * NUM_ROTORS + 1);

  ctl_cmd_t      ctl_cmd;
  ctl_sts_t      ctl_sts;
  logic [KW-1:0] step_k;

  rce_ctrl #(
    .NUM_ROTORS(NUM_ROTORS),
    .KW        (KW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (ctl_sts),
    .cmd     (ctl_cmd),
    .step_k  (step_k)
  );

  rce_datapath #(
    .NUM_ROTORS(NUM_ROTORS),
    .KW        (KW)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .in_cmd  (s_tuser),
    .in_data (s_tdata[20:0]),
    .cmd     (ctl_cmd),
    .step_k  (step_k),
    .sts     (ctl_sts),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  `RCE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `RCE_ASSERT_IMPL(a_no_result_overwrite, ctl_cmd.out_load, !m_tvalid || m_tready)
  `RCE_ASSERT_IMPL(a_final_only_letters, ctl_cmd.final_step, ctl_sts.needs_lookup)
  `RCE_ASSERT_IMPL(a_inverse_only_rotor, ctl_cmd.wr_inv, ctl_sts.needs_inv)

endmodule

`default_nettype wire

@@ hw/rtl/rce_ctrl.sv @@
// sequencing state machine for the rotor cipher engine
// depends on rce_pkg
`default_nettype none

module rce_ctrl #(
  parameter int NUM_ROTORS = rce_pkg::NUM_ROTORS_DEF,
  parameter int KW = $clog2(2 * NUM_ROTORS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire rce_pkg::ctl_sts_t sts,
  output rce_pkg::ctl_cmd_t     cmd,
  output logic [KW-1:0]         step_k
);
  import rce_pkg::*;

  localparam logic [KW-1:0] LAST_STEP = KW'(2 * NUM_ROTORS);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      step_k <= '0;
    end else begin
      state <= state_next;
      if (state == ST_EXEC && sts.needs_lookup) begin
        step_k <= KW'(1);
      end else if (state == ST_LOOK) begin
        step_k <= (step_k == LAST_STEP) ? '0 : step_k + KW'(1);
      end else begin
        step_k <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.needs_lookup) begin
          state_next = ST_LOOK;
        end else if (sts.needs_inv) begin
          state_next = ST_WRINV;
        end else if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_LOOK: begin
        if (step_k == LAST_STEP) state_next = ST_FINAL;
      end
      ST_WRINV, ST_FINAL: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      ST_EXEC: begin
        // rotor wiring writes and lookups start at once, all other items wait for the output
        if (sts.needs_lookup || sts.needs_inv) begin
          cmd.exec = 1'b1;
        end else if (sts.out_free) begin
          cmd.exec     = 1'b1;
          cmd.out_load = 1'b1;
        end
      end
      ST_LOOK: begin
        cmd.look = 1'b1;
      end
      ST_WRINV: begin
        if (sts.out_free) begin
          cmd.wr_inv   = 1'b1;
          cmd.out_load = 1'b1;
        end
      end
      ST_FINAL: begin
        if (sts.out_free) begin
          cmd.final_step = 1'b1;
          cmd.out_load   = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/rce_datapath.sv @@
// rotor cipher datapath: wiring memory, plugboard, rotor registers, result register
// depends on rce_pkg, driven by rce_ctrl
`default_nettype none

module rce_datapath #(
  parameter int NUM_ROTORS = rce_pkg::NUM_ROTORS_DEF,
  parameter int KW = $clog2(2 * NUM_ROTORS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [20:0]       in_data,
  input  wire rce_pkg::ctl_cmd_t cmd,
  input  wire logic [KW-1:0]     step_k,
  output rce_pkg::ctl_sts_t      sts,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [7:0]             m_tdata,
  output logic [1:0]             m_tuser
);
  import rce_pkg::*;

  // rows: forward rotors, reflector, inverse rotors in reverse order
  localparam int DEPTH = (2 * NUM_ROTORS + 1) * LETTERS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = (NUM_ROTORS > 1) ? $clog2(NUM_ROTORS) : 1;
  localparam logic [3:0] NR = 4'(NUM_ROTORS);

  // latched item
  cmd_e_t     cmd_q;
  logic [7:0] ch_q;
  logic [2:0] unit_q;
  logic [4:0] idx_q;
  logic [4:0] val_q;

  logic [4:0] mem [DEPTH];
  logic [4:0] rdata;
  logic [4:0] prev;
  logic [4:0] plug [LETTERS];
  logic [4:0] pos [NUM_ROTORS];
  logic [4:0] notch [NUM_ROTORS];
  status_e_t  status;

  logic          is_space, is_upper, is_lower;
  logic [4:0]    letter_idx;
  logic [3:0]    unit_ext;
  logic          unit_rotor, unit_refl, unit_plug, wr_ok, set_ok;
  logic [RW-1:0] unit_rot;
  logic [RW-1:0] rot_idx;
  logic [4:0]    add_k, sub_k, lk_in, rd_letter, fin_c, plug_addr, plug_rd;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [4:0]    wr_data;
  logic [4:0]    pos_stepped [NUM_ROTORS];
  logic [NUM_ROTORS:0] carry;
  logic [7:0]    res_char;
  status_e_t     res_status;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_q  <= cmd_e_t'(in_cmd);
      ch_q   <= in_data[7:0];
      unit_q <= in_data[10:8];
      idx_q  <= in_data[15:11];
      val_q  <= in_data[20:16];
    end
  end

  // decode of the latched item
  always_comb begin
    is_space   = (ch_q == CHAR_SPACE);
    is_upper   = (ch_q >= CHAR_A) && (ch_q <= CHAR_Z);
    is_lower   = (ch_q >= CHAR_LA) && (ch_q <= CHAR_LZ);
    letter_idx = is_lower ? 5'(ch_q - CHAR_LA) : 5'(ch_q - CHAR_A);
    unit_ext   = {1'b0, unit_q};
    unit_rotor = (unit_ext < NR);
    unit_refl  = (unit_ext == NR);
    unit_plug  = (unit_ext == NR + 4'd1);
    unit_rot   = unit_q[RW-1:0];
    wr_ok      = (cmd_q == CMD_WRITE) && (unit_ext <= NR + 4'd1)
                 && (idx_q < 5'(LETTERS)) && (val_q < 5'(LETTERS));
    set_ok     = unit_rotor && (val_q < 5'(LETTERS));
    sts.needs_lookup = (cmd_q == CMD_ENCIPHER) && (is_upper || is_lower);
    sts.needs_inv    = wr_ok && unit_rotor;
    sts.out_free     = !m_tvalid || m_tready;
  end

  // lookup address: one table read per cycle, fed by the previous read
  always_comb begin
    if (step_k < KW'(NUM_ROTORS)) begin
      rot_idx = RW'(step_k);
    end else if (step_k > KW'(NUM_ROTORS)) begin
      rot_idx = RW'(KW'(2 * NUM_ROTORS) - step_k);
    end else begin
      rot_idx = '0;
    end
    add_k     = (step_k == KW'(NUM_ROTORS)) ? 5'd0 : pos[rot_idx];
    sub_k     = cmd.look ? prev : 5'd0;
    fin_c     = shift26(rdata, prev, 5'd0);
    plug_addr = cmd.final_step ? fin_c : letter_idx;
    plug_rd   = plug[plug_addr];
    lk_in     = cmd.look ? rdata : plug_rd;
    rd_letter = shift26(lk_in, sub_k, add_k);
    rd_addr   = AW'(step_k) * AW'(LETTERS) + AW'(rd_letter);
    rd_en     = (cmd.exec && sts.needs_lookup) || cmd.look;
  end

  // table writes: forward or reflector entry on execute, a rotor's inverse entry in the inverse-write state after it
  always_comb begin
    wr_en = (cmd.exec && wr_ok && (unit_rotor || unit_refl)) || cmd.wr_inv;
    if (cmd.wr_inv) begin
      wr_addr = (AW'(2 * NUM_ROTORS) - AW'(unit_q)) * AW'(LETTERS) + AW'(val_q);
      wr_data = idx_q;
    end else begin
      wr_addr = AW'(unit_q) * AW'(LETTERS) + AW'(idx_q);
      wr_data = val_q;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rd_en) prev <= add_k;
  end

  // odometer stepping, carry on old position equal to notch
  always_comb begin
    carry[0] = 1'b1;
    for (int i = 0; i < NUM_ROTORS; i++) begin
      carry[i+1] = carry[i] && (pos[i] == notch[i]);
      if (!carry[i]) begin
        pos_stepped[i] = pos[i];
      end else if (pos[i] == 5'(LETTERS - 1)) begin
        pos_stepped[i] = 5'd0;
      end else begin
        pos_stepped[i] = pos[i] + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LETTERS; i++) plug[i] <= 5'(i);
      for (int i = 0; i < NUM_ROTORS; i++) begin
        pos[i]   <= 5'd0;
        notch[i] <= 5'd0;
      end
    end else begin
      if (cmd.exec && wr_ok && unit_plug) plug[idx_q] <= val_q;
      if (cmd.exec && set_ok && cmd_q == CMD_SET_POS) pos[unit_rot] <= val_q;
      if (cmd.exec && set_ok && cmd_q == CMD_SET_NOTCH) notch[unit_rot] <= val_q;
      if (cmd.final_step) begin
        for (int i = 0; i < NUM_ROTORS; i++) pos[i] <= pos_stepped[i];
      end
    end
  end

  always_comb begin
    res_char   = 8'd0;
    res_status = STS_OK;
    if (cmd.final_step) begin
      res_char = CHAR_A + 8'(plug_rd);
    end else begin
      case (cmd_q)
        CMD_ENCIPHER: begin
          if (is_space) begin
            res_char = CHAR_SPACE;
          end else begin
            res_status = STS_BAD_CHAR;
          end
        end
        CMD_WRITE: begin
          if (unit_ext > NR + 4'd1) res_status = STS_BAD_UNIT;
        end
        CMD_SET_POS, CMD_SET_NOTCH: begin
          if (!unit_rotor) res_status = STS_BAD_UNIT;
        end
        default: res_status = STS_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= res_char;
      status  <= res_status;
    end
  end

  assign m_tuser = status;

endmodule

`default_nettype wire
